/* hw/rtl/nsc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package nsc_pkg;

   localparam int MAX_LINE = 256;
   localparam int LEN_W    = $clog2(MAX_LINE);
   localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(MAX_LINE - 1);
   localparam logic [LEN_W-1:0] HDR_LEN  = LEN_W'(6);

   localparam logic [3:0] SEP_MAX   = 4'hF;
   localparam logic [3:0] SEP_FIX   = 4'd2;
   localparam logic [3:0] SEP_ENOUGH = 4'd3;

   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_A      = 8'h41;

   typedef enum logic [2:0] {
      ST_UNKNOWN    = 3'd0,
      ST_RMC_VALID  = 3'd1,
      ST_GGA_OK     = 3'd2,
      ST_BAD_SUM    = 3'd3,
      ST_RMC_NO_FIX = 3'd4
   } status_type;

   typedef struct packed {
      status_type  line_status;
      logic [7:0]  computed_sum;
      logic [7:0]  received_sum;
   } result_type;

   function automatic logic [7:0] rmc_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0: c = 8'h24;
         3'd1: c = 8'h47;
         3'd2: c = 8'h50;
         3'd3: c = 8'h52;
         3'd4: c = 8'h4D;
         3'd5: c = 8'h43;
         default: c = CHAR_NUL;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] gga_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0: c = 8'h24;
         3'd1: c = 8'h47;
         3'd2: c = 8'h50;
         3'd3: c = 8'h47;
         3'd4: c = 8'h47;
         3'd5: c = 8'h41;
         default: c = CHAR_NUL;
      endcase
      return c;
   endfunction

   function automatic logic [3:0] hex_value(input logic [7:0] b);
      logic [7:0] t;
      t = 8'h00;
      if (b inside {[8'h41:8'h46]}) begin
         t = b - 8'h37;
      end else if (b inside {[8'h61:8'h66]}) begin
         t = b - 8'h57;
      end else if (b inside {[8'h30:8'h39]}) begin
         t = b - 8'h30;
      end
      return t[3:0];
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/nsc_in_stage.sv */
`timescale 1ns / 1ps
`default_nettype none

module nsc_in_stage
   import nsc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_rx_byte,
   input  wire logic       advance,
   output logic            byte_valid,
   output logic [7:0]      byte_data
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;

   assign req_ready  = !valid_ff || advance;
   assign valid_in   = req_ready ? req_valid : valid_ff;
   assign byte_valid = valid_ff;
   assign byte_data  = byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_valid && req_ready) begin
         byte_ff <= req_rx_byte;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/nsc_line_tracker.sv */
`timescale 1ns / 1ps
`default_nettype none

module nsc_line_tracker
   import nsc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       advance,
   input  wire logic [7:0] byte_data,
   output logic            line_done,
   output result_type      result
);

   logic [LEN_W-1:0] line_length_ff, line_length_in;
   logic             rmc_ok_ff, rmc_ok_in;
   logic             gga_ok_ff, gga_ok_in;
   logic [7:0]       running_xor_ff, running_xor_in;
   logic             star_seen_ff, star_seen_in;
   logic [1:0]       digits_ff, digits_in;
   logic [7:0]       sum_digits_ff, sum_digits_in;
   logic [3:0]       sep_count_ff, sep_count_in;
   logic             fix_flag_ff, fix_flag_in;
   logic             line_ended_ff, line_ended_in;
   logic             too_long_ff, too_long_in;
   logic             scan_stopped_ff, scan_stopped_in;
   logic             fix_pending_ff, fix_pending_in;

   logic             restart;
   logic [LEN_W-1:0] pos;
   logic [7:0]       final_sum;
   status_type       status;

   assign line_done = (byte_data == CHAR_LF);
   assign restart   = (byte_data == CHAR_DOLLAR);

   always_comb begin
      line_length_in  = restart ? '0 : line_length_ff;
      rmc_ok_in       = restart ? 1'b1 : rmc_ok_ff;
      gga_ok_in       = restart ? 1'b1 : gga_ok_ff;
      running_xor_in  = restart ? 8'h00 : running_xor_ff;
      star_seen_in    = restart ? 1'b0 : star_seen_ff;
      digits_in       = restart ? 2'd0 : digits_ff;
      sum_digits_in   = restart ? 8'h00 : sum_digits_ff;
      sep_count_in    = restart ? 4'd0 : sep_count_ff;
      fix_flag_in     = restart ? 1'b0 : fix_flag_ff;
      line_ended_in   = restart ? 1'b0 : line_ended_ff;
      too_long_in     = restart ? 1'b0 : too_long_ff;
      scan_stopped_in = restart ? 1'b0 : scan_stopped_ff;
      fix_pending_in  = restart ? 1'b0 : fix_pending_ff;

      pos = line_length_in;
      if (pos < HDR_LEN) begin
         if (byte_data != rmc_char(pos[2:0])) begin
            rmc_ok_in = 1'b0;
         end
         if (byte_data != gga_char(pos[2:0])) begin
            gga_ok_in = 1'b0;
         end
      end
      if (pos >= LEN_LAST) begin
         too_long_in = 1'b1;
      end else begin
         line_length_in = pos + 1'b1;
      end

      if (star_seen_in) begin
         if (digits_in < 2'd2) begin
            sum_digits_in = {sum_digits_in[3:0], hex_value(byte_data)};
            digits_in     = digits_in + 2'd1;
         end
      end else if (!line_ended_in && pos != '0) begin
         if (byte_data == CHAR_NUL) begin
            line_ended_in = 1'b1;
         end else if (byte_data == CHAR_STAR) begin
            star_seen_in = 1'b1;
         end else begin
            running_xor_in = running_xor_in ^ byte_data;
         end
      end

      if (!scan_stopped_in) begin
         if (byte_data == CHAR_NUL || byte_data == CHAR_CR || byte_data == CHAR_LF) begin
            scan_stopped_in = 1'b1;
         end else begin
            if (fix_pending_in) begin
               fix_flag_in    = (byte_data == CHAR_A);
               fix_pending_in = 1'b0;
            end
            if (byte_data == CHAR_COMMA || byte_data == CHAR_STAR) begin
               if (sep_count_in < SEP_MAX) begin
                  sep_count_in = sep_count_in + 4'd1;
               end
               if (sep_count_in == SEP_FIX) begin
                  fix_pending_in = 1'b1;
               end
            end
         end
      end

      final_sum = sum_digits_in;
      if (star_seen_in && digits_in == 2'd1) begin
         final_sum = {sum_digits_in[3:0], 4'h0};
      end

      if (!rmc_ok_in && !gga_ok_in) begin
         status = ST_UNKNOWN;
      end else if (too_long_in || !star_seen_in || final_sum != running_xor_in) begin
         status = ST_BAD_SUM;
      end else if (rmc_ok_in) begin
         status = (sep_count_in >= SEP_ENOUGH && fix_flag_in) ? ST_RMC_VALID : ST_RMC_NO_FIX;
      end else begin
         status = ST_GGA_OK;
      end
   end

   assign result.line_status  = status;
   assign result.computed_sum = running_xor_in;
   assign result.received_sum = final_sum;

   always_ff @(posedge clock) begin
      if (reset || (advance && line_done)) begin
         line_length_ff  <= '0;
         rmc_ok_ff       <= 1'b1;
         gga_ok_ff       <= 1'b1;
         running_xor_ff  <= 8'h00;
         star_seen_ff    <= 1'b0;
         digits_ff       <= 2'd0;
         sum_digits_ff   <= 8'h00;
         sep_count_ff    <= 4'd0;
         fix_flag_ff     <= 1'b0;
         line_ended_ff   <= 1'b0;
         too_long_ff     <= 1'b0;
         scan_stopped_ff <= 1'b0;
         fix_pending_ff  <= 1'b0;
      end else if (advance) begin
         line_length_ff  <= line_length_in;
         rmc_ok_ff       <= rmc_ok_in;
         gga_ok_ff       <= gga_ok_in;
         running_xor_ff  <= running_xor_in;
         star_seen_ff    <= star_seen_in;
         digits_ff       <= digits_in;
         sum_digits_ff   <= sum_digits_in;
         sep_count_ff    <= sep_count_in;
         fix_flag_ff     <= fix_flag_in;
         line_ended_ff   <= line_ended_in;
         too_long_ff     <= too_long_in;
         scan_stopped_ff <= scan_stopped_in;
         fix_pending_ff  <= fix_pending_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/nsc_out_stage.sv */
`timescale 1ns / 1ps
`default_nettype none

module nsc_out_stage
   import nsc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       load,
   input  wire result_type result,
   output logic            can_load,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [2:0]      rsp_line_status,
   output logic [7:0]      rsp_computed_sum,
   output logic [7:0]      rsp_received_sum
);

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   assign can_load = !valid_ff || rsp_ready;
   assign valid_in = load ? 1'b1 : (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_line_status  = result_ff.line_status;
   assign rsp_computed_sum = result_ff.computed_sum;
   assign rsp_received_sum = result_ff.received_sum;

endmodule

`default_nettype wire

/* hw/rtl/nmea_sentence_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

// Checks NMEA 0183 sentences from a byte stream, one character per item, and
// accepts one item every clock cycle unless the input is stalled. Each byte is
// registered on acceptance and then updates the line state; a newline's result
// is registered in the output stage as the newline leaves the input register.
// A newline waits there while an earlier result is still held, stalling input.
// A result appears only for a newline byte and holds the line status, the XOR
// of the sentence body and the checksum read after the star. RMC and GGA
// headers are recognized; lines longer than the length limit in the package
// report a bad checksum when the header is known.
module nmea_sentence_checker
   import nsc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [2:0]      rsp_line_status,
   output logic [7:0]      rsp_computed_sum,
   output logic [7:0]      rsp_received_sum
);

   logic       byte_valid;
   logic [7:0] byte_data;
   logic       advance;
   logic       line_done;
   logic       can_load;
   logic       load;
   result_type result;

   assign advance = byte_valid && (!line_done || can_load);
   assign load    = advance && line_done;

   nsc_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .advance     (advance),
      .byte_valid  (byte_valid),
      .byte_data   (byte_data)
   );

   nsc_line_tracker u_tracker (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .byte_data (byte_data),
      .line_done (line_done),
      .result    (result)
   );

   nsc_out_stage u_out_stage (
      .clock            (clock),
      .reset            (reset),
      .load             (load),
      .result           (result),
      .can_load         (can_load),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_line_status  (rsp_line_status),
      .rsp_computed_sum (rsp_computed_sum),
      .rsp_received_sum (rsp_received_sum)
   );

`ifndef SYNTHESIS
   a_load_only_on_newline: assert property (@(posedge clock) disable iff (reset)
      load |-> byte_data == CHAR_LF)
      else $error("Result loaded for a byte other than newline.");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !load)
      else $error("Pending result overwritten.");

   a_held_byte_kept: assert property (@(posedge clock) disable iff (reset)
      (byte_valid && !advance) |=> (byte_valid && $stable(byte_data)))
      else $error("Stalled input byte lost.");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_line_status <= ST_RMC_NO_FIX)
      else $error("Line status out of range.");
`endif

endmodule

`default_nettype wire
